// ----- sv/rbl_pkg.sv -----
`default_nettype none

package rbl_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_FRAME_WIDTH  = 1024;
    localparam int DEF_FRAME_HEIGHT = 1024;
    localparam int DEF_MAX_LABELS   = 64;

    localparam int COORD_W = 10;
    localparam int COUNT_W = 21;
    localparam int SUM_W   = 30;
    localparam int SEQ_W   = 16;
    localparam int KEY_W   = SEQ_W + 4;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 128;

    // Statistics kept for one label.
    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [SUM_W-1:0]   sx;
        logic [SUM_W-1:0]   sy;
        logic [COORD_W-1:0] minx;
        logic [COORD_W-1:0] miny;
        logic [COORD_W-1:0] maxx;
        logic [COORD_W-1:0] maxy;
        logic [KEY_W-1:0]   key;
    } stats_t;

endpackage

`default_nettype wire

// ----- sv/rbl_ram.sv -----
`default_nettype none

module rbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered and holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/region_blob_labeler.sv -----
`default_nettype none
// Connected blob labeler for a binary image delivered as 4x4 regions.
//
// Input channel (s_*): one transaction carries one region, its map column and
// row, and tlast marks the last region of a frame. Regions should arrive in
// raster order. The block takes one region at a time: s_tready is high only
// while the labeler is idle. An empty dot, or one that opens a new label, goes
// straight on to the next dot; a dot that joins labelled neighbors first walks
// the parent chain of each to its root, linking two roots that differ, then
// updates the root's statistics. A region is accepted, reads the row above,
// labels its sixteen dots and ends with the write-back to the column store.
//
// Output channel (m_*): after the region carrying tlast, the block folds every
// label into its root (one pass over the labels) and then sends one transaction
// per blob in order of the blob's first dot. Each blob is found by a scan over
// all labels. A frame with no blobs yields one transaction with tuser low.
// tlast marks the final blob of the frame.
// A stalled receiver only holds the output register; the sequencer waits.
// Reset clears all control state, the column tags and the label count.
module region_blob_labeler #(
    parameter int FRAME_WIDTH  = rbl_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = rbl_pkg::DEF_FRAME_HEIGHT,
    parameter int MAX_LABELS   = rbl_pkg::DEF_MAX_LABELS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // region_x [7:0], region_y [15:8], region_bits [31:16]
    input  wire logic [rbl_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tlast,   // frame_end
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // dot_count [20:0], sum_x [50:21], sum_y [80:51], min_x [90:81],
    // min_y [100:91], max_x [110:101], max_y [120:111], zero fill [127:121]
    output logic      [rbl_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                                m_tuser,   // cluster_valid
    output logic                                m_tlast    // last_cluster
);

    import rbl_pkg::*;

    localparam int LW    = $clog2(MAX_LABELS);
    localparam int ABV_W = 8 + 4 * LW;

    typedef enum logic [20:0] {
        S_IDLE     = 21'h000001,
        S_ABOVE    = 21'h000002,
        S_DOT      = 21'h000004,
        S_FIND_RD  = 21'h000008,
        S_FIND_CK  = 21'h000010,
        S_STAT_RD  = 21'h000020,
        S_STAT_WR  = 21'h000040,
        S_NEXT     = 21'h000080,
        S_FLUSH    = 21'h000100,
        S_M_START  = 21'h000200,
        S_MF_RD    = 21'h000400,
        S_MF_CK    = 21'h000800,
        S_MS_RDL   = 21'h001000,
        S_MS_RDR   = 21'h002000,
        S_MS_WR    = 21'h004000,
        S_SC_START = 21'h008000,
        S_SC       = 21'h010000,
        S_OUT_RD   = 21'h020000,
        S_OUT      = 21'h040000,
        S_EMPTY    = 21'h080000,
        S_CLEAR    = 21'h100000
    } state_t;

    state_t state_reg;

    // Region being labelled.
    logic [7:0]  rx_reg, ry_reg;
    logic [15:0] bits_reg;
    logic        fe_reg;
    logic [3:0]  d_reg;                 // dot index: x in [3:2], y in [1:0]
    logic [LW-1:0] topl_reg  [4];       // labels above, per dot column
    logic [LW-1:0] leftc_reg [4];       // labels to the left, per dot row
    logic [LW-1:0] sh_reg    [4];       // last four dot labels, newest first
    logic [LW-1:0] abv_reg   [4];       // bottom row labels of this region

    // Union-find walk.
    logic [LW-1:0] id_reg, tr_reg, find_cur_reg;
    logic          two_reg, link_reg;

    // Frame state.
    logic                left_valid_reg;
    logic [7:0]          lx_reg, ly_reg;
    logic [LW-1:0]       lcol_reg [4];
    logic [255:0]        tag_valid_reg;
    logic [LW-1:0]       used_reg;
    logic [SEQ_W-1:0]    seq_reg;

    // Fold and emit.
    logic [LW-1:0]         l_reg, r_reg, best_reg, nroots_reg, emitted_reg;
    stats_t                lstat_reg;
    logic [KEY_W-1:0]      best_key_reg;
    logic                  bestv_reg;
    logic [MAX_LABELS-1:0] root_reg, done_reg;

    logic m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Memory ports.
    logic               abv_we, abv_re;
    logic [7:0]         abv_raddr;
    logic [ABV_W-1:0]   abv_wdata, abv_rdata;
    logic               par_we, par_re;
    logic [LW-1:0]      par_waddr, par_wdata, par_raddr, par_rdata;
    logic               st_we, st_re;
    logic [LW-1:0]      st_waddr, st_raddr;
    stats_t             st_wdata, st_rdata;

    logic [1:0]          dx, dy;
    logic                dot_bit;
    logic [LW-1:0]       top_lab, left_lab, new_id;
    logic [COORD_W-1:0]  px, py;
    logic                can_alloc, in_frame, out_free, has_top, has_left;
    logic [7:0]          abv_row;
    stats_t              init_stats;

    function automatic stats_t st_add(stats_t s, logic [COORD_W-1:0] ax,
                                      logic [COORD_W-1:0] ay);
        stats_t o;
        o      = s;
        o.cnt  = s.cnt + COUNT_W'(1);
        o.sx   = s.sx + SUM_W'(ax);
        o.sy   = s.sy + SUM_W'(ay);
        o.minx = (ax < s.minx) ? ax : s.minx;
        o.miny = (ay < s.miny) ? ay : s.miny;
        o.maxx = (ax > s.maxx) ? ax : s.maxx;
        o.maxy = (ay > s.maxy) ? ay : s.maxy;
        return o;
    endfunction

    function automatic stats_t st_merge(stats_t r, stats_t l);
        stats_t o;
        o      = r;
        o.cnt  = r.cnt + l.cnt;
        o.sx   = r.sx + l.sx;
        o.sy   = r.sy + l.sy;
        o.minx = (l.minx < r.minx) ? l.minx : r.minx;
        o.miny = (l.miny < r.miny) ? l.miny : r.miny;
        o.maxx = (l.maxx > r.maxx) ? l.maxx : r.maxx;
        o.maxy = (l.maxy > r.maxy) ? l.maxy : r.maxy;
        o.key  = (l.key < r.key) ? l.key : r.key;
        return o;
    endfunction

    assign dx        = d_reg[3:2];
    assign dy        = d_reg[1:0];
    assign dot_bit   = bits_reg[{dx, ~dy}];
    assign top_lab   = (dy == 2'd0) ? topl_reg[dx] : sh_reg[0];
    assign left_lab  = (dx == 2'd0) ? leftc_reg[dy] : sh_reg[3];
    assign px        = {rx_reg, dx};
    assign py        = {ry_reg, dy};
    assign new_id    = used_reg + LW'(1);
    assign can_alloc = used_reg < LW'(MAX_LABELS - 1);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_frame  = ((32'(s_tdata[7:0]) << 2) < FRAME_WIDTH) &&
                       ((32'(s_tdata[15:8]) << 2) < FRAME_HEIGHT);
    assign abv_row   = abv_rdata[ABV_W-1 -: 8];
    assign has_top   = tag_valid_reg[rx_reg] && (ry_reg != 8'd0) &&
                       (abv_row == ry_reg - 8'd1);
    assign has_left  = left_valid_reg && ({1'b0, lx_reg} + 9'd1 == {1'b0, rx_reg}) &&
                       (ly_reg == ry_reg);

    always_comb
    begin
        init_stats      = '0;
        init_stats.cnt  = COUNT_W'(1);
        init_stats.sx   = SUM_W'(px);
        init_stats.sy   = SUM_W'(py);
        init_stats.minx = px;
        init_stats.miny = py;
        init_stats.maxx = px;
        init_stats.maxy = py;
        init_stats.key  = {seq_reg, d_reg};
    end

    // Memory control.
    always_comb
    begin
        abv_re    = 1'b0;
        abv_raddr = s_tdata[7:0];
        abv_we    = 1'b0;
        abv_wdata = {ry_reg, abv_reg[3], abv_reg[2], abv_reg[1], abv_reg[0]};
        par_we    = 1'b0;
        par_waddr = new_id;
        par_wdata = new_id;
        par_re    = 1'b0;
        par_raddr = find_cur_reg;
        st_we     = 1'b0;
        st_waddr  = id_reg;
        st_wdata  = st_add(st_rdata, px, py);
        st_re     = 1'b0;
        st_raddr  = id_reg;
        case (state_reg)
            S_IDLE:
            begin
                abv_re = s_tvalid && in_frame;
            end
            S_DOT:
            begin
                if (dot_bit && top_lab == '0 && left_lab == '0 && can_alloc)
                begin
                    par_we   = 1'b1;
                    st_we    = 1'b1;
                    st_waddr = new_id;
                    st_wdata = init_stats;
                end
            end
            S_FIND_RD, S_MF_RD:
            begin
                par_re = 1'b1;
            end
            S_FIND_CK:
            begin
                if (par_rdata != find_cur_reg)
                begin
                    par_re    = 1'b1;
                    par_raddr = par_rdata;
                end
                else if (link_reg && find_cur_reg != tr_reg)
                begin
                    par_we    = 1'b1;
                    par_waddr = find_cur_reg;
                    par_wdata = tr_reg;
                end
            end
            S_MF_CK:
            begin
                if (par_rdata != find_cur_reg)
                begin
                    par_re    = 1'b1;
                    par_raddr = par_rdata;
                end
            end
            S_STAT_RD:
            begin
                st_re = 1'b1;
            end
            S_STAT_WR:
            begin
                st_we = 1'b1;
            end
            S_FLUSH:
            begin
                abv_we = 1'b1;
            end
            S_MS_RDL:
            begin
                st_re    = 1'b1;
                st_raddr = l_reg;
            end
            S_MS_RDR:
            begin
                st_re    = 1'b1;
                st_raddr = r_reg;
            end
            S_MS_WR:
            begin
                st_we    = 1'b1;
                st_waddr = r_reg;
                st_wdata = st_merge(st_rdata, lstat_reg);
            end
            S_SC_START:
            begin
                st_re    = 1'b1;
                st_raddr = LW'(1);
            end
            S_SC:
            begin
                st_re    = (l_reg != used_reg);
                st_raddr = l_reg + LW'(1);
            end
            S_OUT_RD:
            begin
                st_re    = 1'b1;
                st_raddr = best_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rx_reg         <= '0;
            ry_reg         <= '0;
            bits_reg       <= '0;
            fe_reg         <= 1'b0;
            d_reg          <= '0;
            id_reg         <= '0;
            tr_reg         <= '0;
            find_cur_reg   <= '0;
            two_reg        <= 1'b0;
            link_reg       <= 1'b0;
            left_valid_reg <= 1'b0;
            lx_reg         <= '0;
            ly_reg         <= '0;
            tag_valid_reg  <= '0;
            used_reg       <= '0;
            seq_reg        <= '0;
            l_reg          <= '0;
            r_reg          <= '0;
            best_reg       <= '0;
            nroots_reg     <= '0;
            emitted_reg    <= '0;
            lstat_reg      <= '0;
            best_key_reg   <= '0;
            bestv_reg      <= 1'b0;
            root_reg       <= '0;
            done_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tuser_reg    <= 1'b0;
            m_tlast_reg    <= 1'b0;
            m_tdata_reg    <= '0;
            for (int i = 0; i < 4; i++)
            begin
                topl_reg[i]  <= '0;
                leftc_reg[i] <= '0;
                sh_reg[i]    <= '0;
                abv_reg[i]   <= '0;
                lcol_reg[i]  <= '0;
            end
        end
        else
        begin
            // The emitting states load the output register themselves.
            if (m_tready && !(state_reg inside {S_OUT, S_EMPTY}))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        rx_reg   <= s_tdata[7:0];
                        ry_reg   <= s_tdata[15:8];
                        bits_reg <= s_tdata[31:16];
                        fe_reg   <= s_tlast;
                        if (in_frame)
                        begin
                            state_reg <= S_ABOVE;
                        end
                        else if (s_tlast)
                        begin
                            state_reg <= S_M_START;
                        end
                    end
                end
                S_ABOVE:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        topl_reg[i]  <= has_top ? abv_rdata[i*LW +: LW] : '0;
                        leftc_reg[i] <= has_left ? lcol_reg[i] : '0;
                    end
                    d_reg     <= '0;
                    state_reg <= S_DOT;
                end
                S_DOT:
                begin
                    if (!dot_bit)
                    begin
                        id_reg    <= '0;
                        state_reg <= S_NEXT;
                    end
                    else if (top_lab == '0 && left_lab == '0)
                    begin
                        // A new label, or none once the label space is used up.
                        if (can_alloc)
                        begin
                            id_reg   <= new_id;
                            used_reg <= new_id;
                        end
                        else
                        begin
                            id_reg <= '0;
                        end
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        find_cur_reg <= (top_lab != '0) ? top_lab : left_lab;
                        two_reg      <= (top_lab != '0) && (left_lab != '0);
                        link_reg     <= 1'b0;
                        state_reg    <= S_FIND_RD;
                    end
                end
                S_FIND_RD:
                begin
                    state_reg <= S_FIND_CK;
                end
                S_FIND_CK:
                begin
                    if (par_rdata != find_cur_reg)
                    begin
                        find_cur_reg <= par_rdata;
                    end
                    else if (two_reg)
                    begin
                        // Top root found; now walk from the left neighbor.
                        tr_reg       <= find_cur_reg;
                        find_cur_reg <= left_lab;
                        two_reg      <= 1'b0;
                        link_reg     <= 1'b1;
                        state_reg    <= S_FIND_RD;
                    end
                    else
                    begin
                        id_reg    <= link_reg ? tr_reg : find_cur_reg;
                        link_reg  <= 1'b0;
                        state_reg <= S_STAT_RD;
                    end
                end
                S_STAT_RD:
                begin
                    state_reg <= S_STAT_WR;
                end
                S_STAT_WR:
                begin
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    sh_reg[0] <= id_reg;
                    sh_reg[1] <= sh_reg[0];
                    sh_reg[2] <= sh_reg[1];
                    sh_reg[3] <= sh_reg[2];
                    if (dy == 2'd3)
                    begin
                        abv_reg[dx] <= id_reg;
                    end
                    d_reg <= d_reg + 4'd1;
                    if (d_reg == 4'd15)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        state_reg <= S_DOT;
                    end
                end
                S_FLUSH:
                begin
                    tag_valid_reg[rx_reg] <= 1'b1;
                    for (int i = 0; i < 4; i++)
                    begin
                        lcol_reg[i] <= sh_reg[3-i];
                    end
                    left_valid_reg <= 1'b1;
                    lx_reg         <= rx_reg;
                    ly_reg         <= ry_reg;
                    if (seq_reg != '1)
                    begin
                        seq_reg <= seq_reg + SEQ_W'(1);
                    end
                    state_reg <= fe_reg ? S_M_START : S_IDLE;
                end
                S_M_START:
                begin
                    if (used_reg == '0)
                    begin
                        state_reg <= S_EMPTY;
                    end
                    else
                    begin
                        l_reg        <= LW'(1);
                        find_cur_reg <= LW'(1);
                        state_reg    <= S_MF_RD;
                    end
                end
                S_MF_RD:
                begin
                    state_reg <= S_MF_CK;
                end
                S_MF_CK:
                begin
                    if (par_rdata != find_cur_reg)
                    begin
                        find_cur_reg <= par_rdata;
                    end
                    else if (find_cur_reg == l_reg)
                    begin
                        root_reg[l_reg] <= 1'b1;
                        nroots_reg      <= nroots_reg + LW'(1);
                        if (l_reg == used_reg)
                        begin
                            state_reg <= S_SC_START;
                        end
                        else
                        begin
                            l_reg        <= l_reg + LW'(1);
                            find_cur_reg <= l_reg + LW'(1);
                            state_reg    <= S_MF_RD;
                        end
                    end
                    else
                    begin
                        r_reg     <= find_cur_reg;
                        state_reg <= S_MS_RDL;
                    end
                end
                S_MS_RDL:
                begin
                    state_reg <= S_MS_RDR;
                end
                S_MS_RDR:
                begin
                    lstat_reg <= st_rdata;
                    state_reg <= S_MS_WR;
                end
                S_MS_WR:
                begin
                    if (l_reg == used_reg)
                    begin
                        state_reg <= S_SC_START;
                    end
                    else
                    begin
                        l_reg        <= l_reg + LW'(1);
                        find_cur_reg <= l_reg + LW'(1);
                        state_reg    <= S_MF_RD;
                    end
                end
                S_SC_START:
                begin
                    l_reg     <= LW'(1);
                    bestv_reg <= 1'b0;
                    state_reg <= S_SC;
                end
                S_SC:
                begin
                    // Earliest first dot wins; ties keep the lower label.
                    if (root_reg[l_reg] && !done_reg[l_reg] &&
                        (!bestv_reg || st_rdata.key < best_key_reg))
                    begin
                        bestv_reg    <= 1'b1;
                        best_reg     <= l_reg;
                        best_key_reg <= st_rdata.key;
                    end
                    if (l_reg == used_reg)
                    begin
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        l_reg <= l_reg + LW'(1);
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= 1'b1;
                        m_tlast_reg  <= (emitted_reg + LW'(1) == nroots_reg);
                        m_tdata_reg  <= {7'd0, st_rdata.maxy, st_rdata.maxx,
                                         st_rdata.miny, st_rdata.minx,
                                         st_rdata.sy, st_rdata.sx, st_rdata.cnt};
                        done_reg[best_reg] <= 1'b1;
                        emitted_reg        <= emitted_reg + LW'(1);
                        if (emitted_reg + LW'(1) == nroots_reg)
                        begin
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_SC_START;
                        end
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= 1'b0;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= '0;
                        state_reg    <= S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    tag_valid_reg  <= '0;
                    left_valid_reg <= 1'b0;
                    used_reg       <= '0;
                    seq_reg        <= '0;
                    root_reg       <= '0;
                    done_reg       <= '0;
                    nroots_reg     <= '0;
                    emitted_reg    <= '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        lcol_reg[i] <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Bottom row labels and map row of the last region seen in each column.
    rbl_ram #(.WIDTH(ABV_W), .DEPTH(256)) u_above_ram (
        .clk   (clk),
        .we    (abv_we),
        .waddr (rx_reg),
        .wdata (abv_wdata),
        .re    (abv_re),
        .raddr (abv_raddr),
        .rdata (abv_rdata)
    );

    // Union-find parent links.
    rbl_ram #(.WIDTH(LW), .DEPTH(MAX_LABELS)) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    // Per-label count, sums, bounds and first-dot key.
    rbl_ram #(.WIDTH($bits(stats_t)), .DEPTH(MAX_LABELS)) u_stats_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

endmodule

`default_nettype wire

// ----- sv/rbl_checker.sv -----
`default_nettype none

module rbl_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rbl_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                           m_tuser,
    input wire logic                           m_tlast
);

    // A stalled output transaction stays presented.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction dropped while stalled");

    // A stalled output transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // The empty-frame result is always the last one and carries zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty-frame result malformed");

    // A blob always has at least one dot.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[20:0] != '0))
        else $error("blob with zero dots");

    // While results are being sent, no new region is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted while a frame is still draining");

endmodule

bind region_blob_labeler rbl_checker u_rbl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/region_blob_labeler_tb.sv -----
`timescale 1ns / 100ps

module region_blob_labeler_tb;
    import rbl_pkg::*;

    localparam int MAXL       = DEF_MAX_LABELS;
    localparam int WDOG_LIMIT = 40000;
    localparam int HOLD_LEN   = 3000;

    // One blob as the output channel should present it.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] cnt;
        logic [SUM_W-1:0]   sx;
        logic [SUM_W-1:0]   sy;
        logic [COORD_W-1:0] minx;
        logic [COORD_W-1:0] miny;
        logic [COORD_W-1:0] maxx;
        logic [COORD_W-1:0] maxy;
        logic               last;
    } blob_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    region_blob_labeler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Shadow copy of the labeler state.
    logic [5:0]         col_labels [256][4];
    logic               col_tag_ok [256];
    logic [7:0]         col_tag_row[256];
    logic [5:0]         left_labels[4];
    logic               left_ok;
    logic [7:0]         left_x;
    logic [7:0]         left_y;
    logic [5:0]         parent     [MAXL];
    int unsigned        labels_in_use;
    int unsigned        lab_cnt    [MAXL];
    longint unsigned    lab_sx     [MAXL];
    longint unsigned    lab_sy     [MAXL];
    logic [15:0]        lab_bnd    [MAXL][4];
    logic [KEY_W-1:0]   lab_key    [MAXL];
    int unsigned        seq_idx;

    blob_t       blob_q[$];
    int unsigned mismatches;
    int unsigned regions_sent;
    int unsigned blobs_checked;
    int unsigned frames_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    bit          hold_request;
    bit          timed_out;

    function automatic int unsigned root_of(int unsigned lab);
        int unsigned p;
        lab = lab % MAXL;
        for (int k = 0; k < MAXL; k++)
        begin
            p = parent[lab];
            if (p == lab)
                break;
            lab = p;
        end
        return lab;
    endfunction

    function automatic void clear_frame_state();
        for (int i = 0; i < 256; i++)
            col_tag_ok[i] = 1'b0;
        for (int i = 0; i < 4; i++)
            left_labels[i] = '0;
        left_ok       = 1'b0;
        left_x        = '0;
        left_y        = '0;
        labels_in_use = 0;
        seq_idx       = 0;
    endfunction

    // Label one region dot by dot, x outer and y inner.
    function automatic void label_region(logic [7:0] rx, logic [7:0] ry, logic [15:0] bits);
        logic [5:0]  lmap[4][4];
        bit          has_top;
        bit          has_left;
        int unsigned top;
        int unsigned left;
        int unsigned id;
        int unsigned tr;
        int unsigned lr;
        int unsigned px;
        int unsigned py;
        has_top  = col_tag_ok[rx] && ry != 0 && col_tag_row[rx] == ry - 8'd1;
        has_left = left_ok && ({1'b0, left_x} + 9'd1 == {1'b0, rx}) && left_y == ry;
        for (int x = 0; x < 4; x++)
        begin
            top = has_top ? col_labels[rx][x] : 0;
            for (int y = 0; y < 4; y++)
            begin
                id = 0;
                if (bits[x * 4 + 3 - y])
                begin
                    left = (x > 0) ? lmap[x - 1][y] : (has_left ? left_labels[y] : 0);
                    if (top != 0 && left != 0)
                    begin
                        tr = root_of(top);
                        lr = root_of(left);
                        id = tr;
                        // The left root is hung under the top root.
                        if (lr != tr)
                            parent[lr] = tr[5:0];
                    end
                    else if (top == 0 && left == 0)
                    begin
                        // Out of labels: the dot is dropped and looks empty.
                        if (labels_in_use < MAXL - 1)
                        begin
                            labels_in_use++;
                            id             = labels_in_use;
                            parent[id]     = id[5:0];
                            lab_cnt[id]    = 0;
                            lab_sx[id]     = 0;
                            lab_sy[id]     = 0;
                            lab_bnd[id][0] = 16'hFFFF;
                            lab_bnd[id][1] = 16'hFFFF;
                            lab_bnd[id][2] = 16'h0;
                            lab_bnd[id][3] = 16'h0;
                            lab_key[id]    = {seq_idx[SEQ_W-1:0], 4'(x * 4 + y)};
                        end
                    end
                    else
                    begin
                        id = root_of(top | left);
                    end
                    if (id != 0)
                    begin
                        px = rx * 4 + x;
                        py = ry * 4 + y;
                        lab_cnt[id]++;
                        lab_sx[id] += px;
                        lab_sy[id] += py;
                        if (px < lab_bnd[id][0]) lab_bnd[id][0] = px[15:0];
                        if (py < lab_bnd[id][1]) lab_bnd[id][1] = py[15:0];
                        if (px > lab_bnd[id][2]) lab_bnd[id][2] = px[15:0];
                        if (py > lab_bnd[id][3]) lab_bnd[id][3] = py[15:0];
                    end
                end
                top        = id;
                lmap[x][y] = id[5:0];
            end
        end
        for (int x = 0; x < 4; x++)
            col_labels[rx][x] = lmap[x][3];
        col_tag_ok[rx]  = 1'b1;
        col_tag_row[rx] = ry;
        for (int y = 0; y < 4; y++)
            left_labels[y] = lmap[3][y];
        left_ok = 1'b1;
        left_x  = rx;
        left_y  = ry;
        if (seq_idx < 16'hFFFF)
            seq_idx++;
    endfunction

    // Fold labels into roots and queue one blob per root, ordered by first dot.
    function automatic void queue_frame_blobs();
        int unsigned roots[$];
        int unsigned r;
        int unsigned v;
        int          j;
        blob_t       b;
        for (int unsigned l = 1; l <= labels_in_use; l++)
        begin
            r = root_of(l);
            if (r == l)
            begin
                roots = {roots, l};
                continue;
            end
            lab_cnt[r] += lab_cnt[l];
            lab_sx[r]  += lab_sx[l];
            lab_sy[r]  += lab_sy[l];
            if (lab_bnd[l][0] < lab_bnd[r][0]) lab_bnd[r][0] = lab_bnd[l][0];
            if (lab_bnd[l][1] < lab_bnd[r][1]) lab_bnd[r][1] = lab_bnd[l][1];
            if (lab_bnd[l][2] > lab_bnd[r][2]) lab_bnd[r][2] = lab_bnd[l][2];
            if (lab_bnd[l][3] > lab_bnd[r][3]) lab_bnd[r][3] = lab_bnd[l][3];
            if (lab_key[l] < lab_key[r]) lab_key[r] = lab_key[l];
        end
        // Stable insertion sort keeps label order for equal keys.
        for (int i = 1; i < roots.size(); i++)
        begin
            v = roots[i];
            j = i;
            while (j > 0 && lab_key[roots[j - 1]] > lab_key[v])
            begin
                roots[j] = roots[j - 1];
                j--;
            end
            roots[j] = v;
        end
        if (roots.size() == 0)
        begin
            b      = '0;
            b.last = 1'b1;
            blob_q = {blob_q, b};
        end
        for (int i = 0; i < roots.size(); i++)
        begin
            r      = roots[i];
            b.valid = 1'b1;
            b.cnt  = lab_cnt[r][COUNT_W-1:0];
            b.sx   = lab_sx[r][SUM_W-1:0];
            b.sy   = lab_sy[r][SUM_W-1:0];
            b.minx = lab_bnd[r][0][COORD_W-1:0];
            b.miny = lab_bnd[r][1][COORD_W-1:0];
            b.maxx = lab_bnd[r][2][COORD_W-1:0];
            b.maxy = lab_bnd[r][3][COORD_W-1:0];
            b.last = (i == roots.size() - 1);
            blob_q = {blob_q, b};
        end
    endfunction

    function automatic void predict_region(logic [7:0] rx, logic [7:0] ry,
                                           logic [15:0] bits, logic fe);
        if (rx * 4 < DEF_FRAME_WIDTH && ry * 4 < DEF_FRAME_HEIGHT)
            label_region(rx, ry, bits);
        if (fe)
        begin
            queue_frame_blobs();
            clear_frame_state();
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Send one region; the sender runs in bursts with idle gaps in between.
    task automatic send_region(logic [7:0] rx, logic [7:0] ry, logic [15:0] bits, logic fe);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {bits, ry, rx};
        s_tlast  <= fe;
        do
            @(posedge clk);
        while (!s_tready);
        predict_region(rx, ry, bits, fe);
        regions_sent++;
        if (fe)
            frames_sent++;
    endtask

    // Send a w by h block of regions in raster order; content is random or, for density 2, full.
    task automatic send_frame(int unsigned w, int unsigned h, int unsigned density);
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [15:0] bits;
        x0 = 8'($urandom_range(0, 256 - w));
        y0 = 8'($urandom_range(0, 256 - h));
        for (int unsigned r = 0; r < h; r++)
            for (int unsigned c = 0; c < w; c++)
            begin
                case (density)
                    0: bits = 16'($urandom & $urandom);
                    1: bits = 16'($urandom | $urandom);
                    2: bits = 16'hFFFF;
                    default: bits = 16'($urandom);
                endcase
                send_region(8'(x0 + c), 8'(y0 + r), bits, (r == h - 1) && (c == w - 1));
            end
    endtask

    // Stop offering and wait until every predicted blob has been seen.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (blob_q.size() != 0);
    endtask

    task automatic test_directed();
        // Single dots in the extreme regions: one in a corner, one on the right edge.
        send_region(8'd0, 8'd0, 16'h0008, 1'b1);
        send_region(8'd255, 8'd255, 16'h4000, 1'b1);
        // An empty frame yields a single no-blob transaction.
        send_region(8'd10, 8'd10, 16'h0000, 1'b1);
        // Full regions across a 2x2 block form one blob.
        send_region(8'd0, 8'd0, 16'hFFFF, 1'b0);
        send_region(8'd1, 8'd0, 16'hFFFF, 1'b0);
        send_region(8'd0, 8'd1, 16'hFFFF, 1'b0);
        send_region(8'd1, 8'd1, 16'hFFFF, 1'b1);
        // Four regions of lines and columns forming four blobs, two across a region boundary.
        send_region(8'd4, 8'd4, 16'h8888, 1'b0);
        send_region(8'd5, 8'd4, 16'h8008, 1'b0);
        send_region(8'd4, 8'd5, 16'hF888, 1'b0);
        send_region(8'd5, 8'd5, 16'hF00F, 1'b1);
        // Checkerboard regions use up every label; later dots are dropped.
        for (int i = 0; i < 9; i++)
            send_region(8'(20 + i), 8'd30, 16'h5A5A, i == 8);
        // Regions out of raster order still follow the neighbor rules.
        send_region(8'd7, 8'd3, 16'h1234, 1'b0);
        send_region(8'd6, 8'd3, 16'hFFFF, 1'b0);
        send_region(8'd7, 8'd2, 16'hFFFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_random(int unsigned n_items);
        int unsigned stop_at;
        stop_at = regions_sent + n_items;
        while (regions_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: scattered regions anywhere in the map.
                repeat ($urandom_range(1, 6))
                    send_region(8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
                send_region(8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
            end
            else
            begin
                send_frame($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 3));
            end
        end
        wait_drained();
    endtask

    // Hold the receiver off while the sender keeps offering a few frames.
    task automatic test_backpressure();
        hold_request = 1'b1;
        wait (hold_count != 0);
        hold_request = 1'b0;
        for (int i = 0; i < 4; i++)
            send_frame(3, 2, 3);
        wait_drained();
    endtask

    // Output side: check each blob transaction, then choose the next tready.
    int unsigned hold_count;
    always @(posedge clk)
    begin
        blob_t got;
        blob_t want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[20:0], m_tdata[50:21], m_tdata[80:51], m_tdata[90:81],
                   m_tdata[100:91], m_tdata[110:101], m_tdata[120:111], m_tlast};
            blobs_checked++;
            if (blob_q.size() == 0)
            begin
                report_mismatch("unexpected blob", 64'(got.cnt), 64'd0);
            end
            else
            begin
                want = blob_q.pop_front();
                if (got.valid != want.valid)
                    report_mismatch("cluster_valid", 64'(got.valid), 64'(want.valid));
                if (got.cnt != want.cnt)
                    report_mismatch("dot_count", 64'(got.cnt), 64'(want.cnt));
                if (got.sx != want.sx)
                    report_mismatch("sum_x", 64'(got.sx), 64'(want.sx));
                if (got.sy != want.sy)
                    report_mismatch("sum_y", 64'(got.sy), 64'(want.sy));
                if (got.minx != want.minx)
                    report_mismatch("min_x", 64'(got.minx), 64'(want.minx));
                if (got.miny != want.miny)
                    report_mismatch("min_y", 64'(got.miny), 64'(want.miny));
                if (got.maxx != want.maxx)
                    report_mismatch("max_x", 64'(got.maxx), 64'(want.maxx));
                if (got.maxy != want.maxy)
                    report_mismatch("max_y", 64'(got.maxy), 64'(want.maxy));
                if (got.last != want.last)
                    report_mismatch("last_cluster", 64'(got.last), 64'(want.last));
            end
        end
        if (hold_request)
            hold_count = HOLD_LEN;
        if (hold_count != 0)
        begin
            hold_count--;
            m_tready <= 1'b0;
        end
        else
        begin
            // Stall pattern: mostly ready, with runs of stalls now and then.
            m_tready <= ($urandom_range(0, 15) < 11);
        end
    end

    // Watchdog over cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d blobs outstanding", blob_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        mismatches    = 0;
        regions_sent  = 0;
        blobs_checked = 0;
        frames_sent   = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        hold_request  = 1'b0;
        hold_count    = 0;
        timed_out     = 1'b0;
        for (int i = 0; i < MAXL; i++)
            parent[i] = '0;
        clear_frame_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random(410);

        s_tvalid <= 1'b0;
        repeat (2000) @(posedge clk);
        $display("Sent %0d regions in %0d frames and checked %0d blob transactions,",
                 regions_sent, frames_sent, blobs_checked);
        $display("covering label merges, label exhaustion, empty frames and a long stall.");
        if (mismatches == 0 && blob_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
